[src/integer_to_radix_ascii_macros.svh]
// assertion macros for the integer to radix ascii converter
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

`ifndef SYNTHESIS
`define ITRA_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");
`define ITRA_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ITRA_ASSERT(lbl, clk_s, rstn_s, prop)
`define ITRA_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

[src/itra_pkg.sv]
// types, constants and helpers shared by the radix conversion modules
`timescale 1ns / 1ps

package itra_pkg;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } itra_state_t;

  typedef struct packed {
    logic load;
    logic next;
  } div_cmd_t;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_DEC_MAX) begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] s;
    if (r < RADIX_MIN) begin
      s = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      s = RADIX_MAX;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

[src/itra_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module itra_divider
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_cmd_t               cmd,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output div_stat_t              stat,
  output logic [DIGIT_W-1:0]     remainder
);

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] work_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     base_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [DIGIT_W:0]   shifted;
  logic [DIGIT_W+1:0] diff;
  logic               ge;

  always_comb begin
    shifted = {rem_r, work_r[VALUE_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, base_r};
    ge      = !diff[DIGIT_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load || cmd.next) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= dividend;
      base_r <= divisor;
      rem_r  <= '0;
    end else if (cmd.next) begin
      rem_r <= '0;
    end else if (busy_r) begin
      work_r <= {work_r[VALUE_WIDTH-2:0], ge};
      rem_r  <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end
  end

  assign stat.done     = done_r;
  assign stat.quo_zero = (work_r == '0);
  assign remainder     = rem_r;

endmodule

[src/itra_digit_stack.sv]
// shift-register digit stack, last digit pushed comes out first
`timescale 1ns / 1ps

module itra_digit_stack
  import itra_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  stk_cmd_t           cmd,
  input  logic [DIGIT_W-1:0] push_digit,
  output logic [DIGIT_W-1:0] top_digit
);

  logic [DIGIT_W-1:0] stk_r [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_r[0] <= push_digit;
      for (int i = 1; i < DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  assign top_digit = stk_r[0];

endmodule

[src/integer_to_radix_ascii.sv]
// each digit comes from one pass of the bit-serial divider
// an item of d digits gives d output characters, plus one for a sign
// the serial divider sets the rate: one quotient bit per cycle, one digit per pass
// the next item is taken once the last character is in the output register
// reset (rst_n low, synchronous) empties the output register and returns to idle
`timescale 1ns / 1ps

`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_bits[31:0], radix[37:32], zero pad[39:38]
  input  logic        in_tuser,   // signed_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // text_char[7:0]
  output logic        out_tlast
);

  localparam int NW = $clog2(VALUE_WIDTH + 1);
  localparam logic [NW-1:0] N_ONE = NW'(1);

  itra_state_t state_r, state_nxt;
  logic              neg_r;
  logic [NW-1:0]     n_r, n_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic                   in_fire;
  logic                   slot_free;
  logic [VALUE_WIDTH-1:0] word;
  logic                   word_neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RADIX_W-1:0]     base;

  div_cmd_t           div_cmd;
  div_stat_t          div_stat;
  logic [DIGIT_W-1:0] rem_digit;
  stk_cmd_t           stk_cmd;
  logic [DIGIT_W-1:0] top_digit;

  logic              out_load;
  logic [CHAR_W-1:0] char_nxt;
  logic              last_nxt;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign word     = VALUE_WIDTH'(in_tdata[31:0]);
  assign word_neg = in_tuser && word[VALUE_WIDTH-1];
  assign mag      = word_neg ? (~word + 1'b1) : word;
  assign base     = sat_radix(in_tdata[37:32]);

  itra_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (mag),
    .divisor  (base),
    .stat     (div_stat),
    .remainder(rem_digit)
  );

  itra_digit_stack #(
    .DEPTH(VALUE_WIDTH)
  ) u_stk (
    .clk       (clk),
    .cmd       (stk_cmd),
    .push_digit(rem_digit),
    .top_digit (top_digit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done && div_stat.quo_zero) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && n_r == N_ONE) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready   = 1'b0;
    div_cmd     = '0;
    stk_cmd     = '0;
    out_load    = 1'b0;
    char_nxt    = CHAR_MINUS;
    last_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        div_cmd.load = in_fire;
      end
      ST_DIV: begin
        stk_cmd.push = div_stat.done;
        div_cmd.next = div_stat.done && !div_stat.quo_zero;
      end
      ST_SIGN: begin
        out_load = slot_free;
      end
      ST_EMIT: begin
        out_load    = slot_free;
        stk_cmd.pop = slot_free;
        char_nxt    = digit_char(top_digit);
        last_nxt    = (n_r == N_ONE);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    n_nxt = n_r;
    if (stk_cmd.push) begin
      n_nxt = n_r + 1'b1;
    end else if (stk_cmd.pop) begin
      n_nxt = n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      if (in_fire) neg_r <= word_neg;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  `ITRA_ASSERT_NEVER(a_push_pop_excl, clk, rst_n, stk_cmd.push && stk_cmd.pop)
  `ITRA_ASSERT(a_count_bound, clk, rst_n, n_r <= NW'(VALUE_WIDTH))
  `ITRA_ASSERT(a_idle_empty, clk, rst_n, in_tready |-> (n_r == '0))
  `ITRA_ASSERT(a_last_ends, clk, rst_n, (out_load && last_nxt) |=> (state_r == ST_IDLE))

endmodule
